// ===== src/fpc_pkg.sv =====
// Shared types, codes and arithmetic helpers for the pixel format converter.
`default_nettype none
package fpc_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 9;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_MODE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RED_POSITION   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RED_BITS       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GREEN_POSITION = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GREEN_BITS     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BLUE_POSITION  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_BLUE_BITS      = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_COUNT  = 3'd7;

  // output modes
  localparam logic [1:0] MODE_DIRECT  = 2'd0;
  localparam logic [1:0] MODE_PALETTE = 2'd1;
  localparam logic [1:0] MODE_MONO    = 2'd2;

  // input word actions
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_CONVERT = 1'b1;

  typedef struct packed {
    logic [1:0] output_mode;
    logic [4:0] red_position;
    logic [3:0] red_bits;
    logic [4:0] green_position;
    logic [3:0] green_bits;
    logic [4:0] blue_position;
    logic [3:0] blue_bits;
    logic [8:0] palette_count;
  } cfg_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } ctrl_state_t;

  typedef struct packed {
    logic take;       // input word accepted this cycle
    logic searching;  // palette walk in progress
    logic finish;     // palette walk result goes out this cycle
  } dp_cmd_t;

  typedef struct packed {
    logic needs_search;  // offered word starts a palette walk
    logic search_done;   // last palette compare retired
    logic hold_full;     // skid register occupied
  } dp_status_t;

  // (c * 255) / 31 for a 5-bit channel
  localparam logic [7:0] EXPAND5 [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  // floor(x / 3) for x < 768, reciprocal multiply
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [25:0] prod;
    prod = 26'(x) * 26'd43691;
    return prod[24:17];
  endfunction

  function automatic logic [31:0] place_channel(input logic [4:0] c5,
                                                input logic [3:0] bits,
                                                input logic [4:0] pos);
    logic [7:0] wide;
    logic [3:0] keep;
    logic [7:0] v;
    wide = EXPAND5[c5];
    keep = (bits > 4'd8) ? 4'd8 : bits;
    v    = (keep == 4'd0) ? 8'd0 : (wide >> (4'd8 - keep));
    return {24'd0, v} << pos;
  endfunction

  function automatic logic [7:0] pixel_average(input logic [14:0] px);
    logic [9:0] sum;
    sum = {2'b00, px[14:10], 3'b000} + {2'b00, px[9:5], 3'b000}
        + {2'b00, px[4:0], 3'b000};
    return div3(sum);
  endfunction

  function automatic logic [7:0] entry_average(input logic [7:0] r,
                                               input logic [7:0] g,
                                               input logic [7:0] b);
    logic [9:0] sum;
    sum = {2'b00, r} + {2'b00, g} + {2'b00, b};
    return div3(sum);
  endfunction

endpackage
`default_nettype wire

// ===== src/fpc_cfg_regs.sv =====
// Configuration register file of the pixel format converter.
`default_nettype none
module fpc_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [fpc_pkg::CFG_INDEX_W-1:0] wr_index,
  input  wire logic [fpc_pkg::CFG_DATA_W-1:0]  wr_data,
  output fpc_pkg::cfg_t                       cfg
);
  import fpc_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_OUTPUT_MODE:    cfg_nxt.output_mode    = wr_data[1:0];
        REG_RED_POSITION:   cfg_nxt.red_position   = wr_data[4:0];
        REG_RED_BITS:       cfg_nxt.red_bits       = wr_data[3:0];
        REG_GREEN_POSITION: cfg_nxt.green_position = wr_data[4:0];
        REG_GREEN_BITS:     cfg_nxt.green_bits     = wr_data[3:0];
        REG_BLUE_POSITION:  cfg_nxt.blue_position  = wr_data[4:0];
        REG_BLUE_BITS:      cfg_nxt.blue_bits      = wr_data[3:0];
        REG_PALETTE_COUNT:  cfg_nxt.palette_count  = wr_data[8:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.output_mode    <= MODE_DIRECT;
      cfg_r.red_position   <= 5'd16;
      cfg_r.red_bits       <= 4'd8;
      cfg_r.green_position <= 5'd8;
      cfg_r.green_bits     <= 4'd8;
      cfg_r.blue_position  <= 5'd0;
      cfg_r.blue_bits      <= 4'd8;
      cfg_r.palette_count  <= 9'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== src/fpc_ctrl.sv =====
// Controller state machine: input acceptance and palette walk sequencing.
`default_nettype none
module fpc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  fpc_pkg::dp_status_t   status,
  output fpc_pkg::dp_cmd_t      cmd
);
  import fpc_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        take;

  assign take = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take && status.needs_search) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (status.search_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    cmd.take      = 1'b0;
    cmd.searching = 1'b0;
    cmd.finish    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = status.hold_full;
        cmd.take = in_valid && !status.hold_full;
      end
      ST_SEARCH: begin
        cmd.searching = 1'b1;
        cmd.finish    = status.search_done;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/fpc_datapath.sv =====
// Datapath: channel packing, palette memory and walk, mono packer, output skid.
`default_nettype none
module fpc_datapath #(
  parameter int PALETTE_DEPTH = fpc_pkg::PALETTE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  fpc_pkg::cfg_t    cfg,
  input  fpc_pkg::dp_cmd_t cmd,
  output fpc_pkg::dp_status_t status,
  input  wire logic        in_action,
  input  wire logic [14:0] in_pixel_color,
  input  wire logic [7:0]  in_entry_index,
  input  wire logic [7:0]  in_entry_red,
  input  wire logic [7:0]  in_entry_green,
  input  wire logic [7:0]  in_entry_blue,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_native_value
);
  import fpc_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int CW = $clog2(PALETTE_DEPTH + 1);
  localparam logic [8:0] DEPTH9 = 9'(PALETTE_DEPTH);

  // palette memory holds each entry's channel average
  logic [7:0]    pal_mem [PALETTE_DEPTH];
  logic [7:0]    rdata_r;

  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic          rd_valid_r, rd_valid_nxt;
  logic [7:0]    avg_r, avg_nxt;
  logic [8:0]    best_r, best_nxt;
  logic [AW-1:0] pick_r, pick_nxt;

  logic [7:0]    mono_shift_r, mono_shift_nxt;
  logic [2:0]    mono_count_r, mono_count_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_data_r, out_data_nxt;
  logic          hold_valid_r, hold_valid_nxt;
  logic [31:0]   hold_data_r, hold_data_nxt;

  logic          convert, pal_we, issuing, prod;
  logic [7:0]    px_avg, diff, mono_byte;
  logic [8:0]    n_full;
  logic [31:0]   direct_val, imm_val, res_val;
  logic          res_valid, out_free;

  assign convert  = (in_action == ACT_CONVERT);
  assign px_avg   = pixel_average(in_pixel_color);
  assign n_full   = (cfg.palette_count > DEPTH9) ? DEPTH9 : cfg.palette_count;
  assign pal_we   = cmd.take && !convert && ({1'b0, in_entry_index} < DEPTH9);
  assign issuing  = cmd.searching && (idx_r < n_r);
  assign mono_byte = {mono_shift_r[6:0], px_avg[7]};

  assign direct_val =
      place_channel(in_pixel_color[14:10], cfg.red_bits, cfg.red_position) |
      place_channel(in_pixel_color[9:5], cfg.green_bits, cfg.green_position) |
      place_channel(in_pixel_color[4:0], cfg.blue_bits, cfg.blue_position);

  assign status.needs_search = convert && (cfg.output_mode == MODE_PALETTE) &&
                               (cfg.palette_count != 9'd0);
  assign status.search_done  = !issuing && !rd_valid_r;
  assign status.hold_full    = hold_valid_r;

  // direct, mono and empty-palette results are available in the cycle the word is taken
  always_comb begin
    prod    = 1'b0;
    imm_val = 32'd0;
    if (convert) begin
      case (cfg.output_mode)
        MODE_DIRECT: begin
          prod    = 1'b1;
          imm_val = direct_val;
        end
        MODE_PALETTE: begin
          prod    = (cfg.palette_count == 9'd0);  // empty palette gives index 0
          imm_val = 32'd0;
        end
        MODE_MONO: begin
          prod    = (mono_count_r == 3'd7);
          imm_val = {24'd0, mono_byte};
        end
        default: prod = 1'b0;
      endcase
    end
  end

  assign res_valid = (cmd.take && prod) || cmd.finish;
  assign res_val   = cmd.finish ? 32'(pick_r) : imm_val;

  // mono gatherer
  always_comb begin
    mono_shift_nxt = mono_shift_r;
    mono_count_nxt = mono_count_r;
    if (cmd.take && convert && (cfg.output_mode == MODE_MONO)) begin
      if (mono_count_r == 3'd7) begin
        mono_shift_nxt = 8'd0;
        mono_count_nxt = 3'd0;
      end else begin
        mono_shift_nxt = mono_byte;
        mono_count_nxt = mono_count_r + 3'd1;
      end
    end
  end

  // palette walk: one read issued per cycle, compared in the cycle after
  assign diff = (rdata_r >= avg_r) ? (rdata_r - avg_r) : (avg_r - rdata_r);

  always_comb begin
    idx_nxt      = idx_r;
    n_nxt        = n_r;
    avg_nxt      = avg_r;
    best_nxt     = best_r;
    pick_nxt     = pick_r;
    rd_idx_nxt   = rd_idx_r;
    rd_valid_nxt = 1'b0;
    if (cmd.take && status.needs_search) begin
      idx_nxt  = '0;
      n_nxt    = CW'(n_full);
      avg_nxt  = px_avg;
      best_nxt = '1;
      pick_nxt = '0;
    end else begin
      if (issuing) begin
        rd_idx_nxt   = idx_r[AW-1:0];
        rd_valid_nxt = 1'b1;
        idx_nxt      = idx_r + CW'(1);
      end
      // strict less-than keeps the lowest index on ties
      if (rd_valid_r && ({1'b0, diff} < best_r)) begin
        best_nxt = {1'b0, diff};
        pick_nxt = rd_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[in_entry_index[AW-1:0]] <=
          entry_average(in_entry_red, in_entry_green, in_entry_blue);
    end
    if (issuing) begin
      rdata_r <= pal_mem[idx_r[AW-1:0]];
    end
  end

  // output register with one skid entry behind it
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    hold_valid_nxt = hold_valid_r;
    hold_data_nxt  = hold_data_r;
    if (out_free) begin
      if (hold_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = hold_data_r;
        hold_valid_nxt = res_valid;
        hold_data_nxt  = res_val;
      end else begin
        out_valid_nxt = res_valid;
        out_data_nxt  = res_val;
      end
    end else if (res_valid) begin
      hold_valid_nxt = 1'b1;
      hold_data_nxt  = res_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r   <= 1'b0;
      idx_r        <= '0;
      n_r          <= '0;
      mono_shift_r <= 8'd0;
      mono_count_r <= 3'd0;
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      rd_valid_r   <= rd_valid_nxt;
      idx_r        <= idx_nxt;
      n_r          <= n_nxt;
      mono_shift_r <= mono_shift_nxt;
      mono_count_r <= mono_count_nxt;
      out_valid_r  <= out_valid_nxt;
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    avg_r       <= avg_nxt;
    best_r      <= best_nxt;
    pick_r      <= pick_nxt;
    out_data_r  <= out_data_nxt;
    hold_data_r <= hold_data_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_native_value = out_data_r;

endmodule
`default_nettype wire

// ===== src/framebuffer_pixel_format_converter_top.sv =====
// Top level of the RGB555 to native pixel format converter.
`default_nettype none
// Converts RGB555 pixel words into the display's native format. Each input
// word either loads one palette entry (action 0) or converts one pixel
// (action 1). Direct mode expands each 5-bit channel to 8 bits, keeps the
// top red/green/blue_bits bits and ORs them in at the set positions (bits
// pushed past bit 31 are lost): one word per cycle unless the output
// stalls, one result each. Mono mode thresholds the channel average at
// 128 and packs eight pixels MSB first; a byte comes out on every eighth
// pixel, one word per cycle unless the output stalls. The gatherer
// survives mode changes and is cleared only by reset or by sending a byte,
// so lines must be multiples of eight pixels. Palette mode walks the
// loaded entries through a single-port palette RAM, one read per cycle, and
// returns the lowest index whose average lies nearest to the pixel's; the
// input is held off while a pixel's walk runs, and an empty palette gives
// index 0 at once. Palette loads at or above PALETTE_DEPTH are dropped;
// entries must be loaded before they are searched. Results sit in an
// output register with one skid word behind it, so a word is still taken
// while a result waits. Configuration writes are taken every cycle
// (cfg_ready is tied high) and must only happen while the block is idle.
module framebuffer_pixel_format_converter_top #(
  parameter int PALETTE_DEPTH = fpc_pkg::PALETTE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input words
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_action,
  input  wire logic [14:0]                     in_pixel_color,
  input  wire logic [7:0]                      in_entry_index,
  input  wire logic [7:0]                      in_entry_red,
  input  wire logic [7:0]                      in_entry_green,
  input  wire logic [7:0]                      in_entry_blue,
  // result words
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [31:0]                          out_native_value,
  // register writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [fpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [fpc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fpc_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  fpc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // sequencing: accepts words in idle, holds input off during a palette walk
  fpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  fpc_datapath #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .status           (status),
    .in_action        (in_action),
    .in_pixel_color   (in_pixel_color),
    .in_entry_index   (in_entry_index),
    .in_entry_red     (in_entry_red),
    .in_entry_green   (in_entry_green),
    .in_entry_blue    (in_entry_blue),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_native_value (out_native_value)
  );

endmodule
`default_nettype wire

// ===== src/fpc_checker.sv =====
// Port-level assertions for the pixel format converter, bound to its top level.
`default_nettype none
module fpc_port_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        in_action,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_native_value,
  input wire logic        cfg_ready
);
  import fpc_pkg::*;

  // a stalled result word stays offered
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word withdrawn while stalled");

  // a stalled result word keeps its value
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_native_value))
    else $error("result word changed while stalled");

  // a palette load never yields a result word
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_action == ACT_LOAD) && !out_valid |=> !out_valid)
    else $error("palette load produced a result word");

  // nothing comes out straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result word present after reset");

  // register writes are never refused
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("register write refused");

endmodule

bind framebuffer_pixel_format_converter_top fpc_port_checker u_fpc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_action        (in_action),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_native_value (out_native_value),
  .cfg_ready        (cfg_ready)
);
`default_nettype wire
